// ----- sv/pfp_pkg.sv -----
`default_nettype none
package pfp_pkg;

  // command codes, upper nibble of the header byte
  localparam logic [3:0] CMD_CONNACK = 4'h2;
  localparam logic [3:0] CMD_PUB     = 4'h3;
  localparam logic [3:0] CMD_PUBACK  = 4'h4;
  localparam logic [3:0] CMD_SUBACK  = 4'h6;
  localparam logic [3:0] CMD_PINGACK = 4'hD;

  // result kinds
  localparam logic [2:0] KIND_PUB_BYTE  = 3'd0;
  localparam logic [2:0] KIND_PUB_EMPTY = 3'd1;
  localparam logic [2:0] KIND_CONNACK   = 3'd2;
  localparam logic [2:0] KIND_PUBACK    = 3'd3;
  localparam logic [2:0] KIND_SUBACK    = 3'd4;
  localparam logic [2:0] KIND_PINGACK   = 3'd5;
  localparam logic [2:0] KIND_FRAME_ERR = 3'd6;

  localparam logic [1:0] CID_LAST_INDEX = 2'd3;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [7:0]  payload_byte;
    logic        last_of_message;
    logic [7:0]  stream_id;
    logic [31:0] sub_channel;
    logic [1:0]  qos_level;
    logic [3:0]  header_flags;
    logic [15:0] message_length;
    logic        ack_needed;
  } evt_t;

endpackage
`default_nettype wire

// ----- sv/pfp_rx_if.sv -----
`default_nettype none
interface pfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ----- sv/pfp_evt_if.sv -----
`default_nettype none
interface pfp_evt_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [7:0]  payload_byte;
  logic        last_of_message;
  logic [7:0]  stream_id;
  logic [31:0] sub_channel;
  logic [1:0]  qos_level;
  logic [3:0]  header_flags;
  logic [15:0] message_length;
  logic        ack_needed;

  modport source (
    output valid, output event_kind, output payload_byte, output last_of_message,
    output stream_id, output sub_channel, output qos_level, output header_flags,
    output message_length, output ack_needed, input ready
  );
  modport sink (
    input valid, input event_kind, input payload_byte, input last_of_message,
    input stream_id, input sub_channel, input qos_level, input header_flags,
    input message_length, input ack_needed, output ready
  );
endinterface
`default_nettype wire

// ----- sv/pubsub_frame_parser.sv -----
`default_nettype none
// channel  | dir | payload                                   | role
// ---------+-----+-------------------------------------------+---------------------------
// rx       | in  | rx_byte[7:0]                              | received frame bytes
// evt      | out | event_kind, payload_byte, last_of_message,| deframed events and
//          |     | stream_id, sub_channel, qos_level,        | streamed publish payload
//          |     | header_flags, message_length, ack_needed  |
//
// one byte per cycle sustained while evt does not stall; a byte's event reaches the
// result register through the input register, then the phase logic
// synchronous active-high rst returns the deframer to waiting for a header and
// empties both registers
// a stall on evt backs up through the result register and the input register to
// rx.ready; every byte, also one that gives no result, waits for room in the
// result register before it is consumed
module pubsub_frame_parser
  import pfp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  pfp_rx_if.sink    rx,
  pfp_evt_if.source evt
);

  // input register
  logic       rx_q_valid;
  logic [7:0] rx_q;

  // deframer to result register
  logic       ev_valid;
  evt_t       ev;
  logic       can_load;
  logic       advance;

  // the held byte moves on once the result register has room for its event
  assign advance  = rx_q_valid && can_load;
  assign rx.ready = !rx_q_valid || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_q_valid <= 1'b0;
    end else if (rx.ready) begin
      rx_q_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      rx_q <= rx.rx_byte;
    end
  end

  // phase logic; state steps once per consumed byte
  pfp_deframer u_deframer (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .rx_byte  (rx_q),
    .ev_valid (ev_valid),
    .ev       (ev)
  );

  // result register, refilled in the same cycle its content is taken
  pfp_result_reg u_result (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && ev_valid),
    .ev       (ev),
    .can_load (can_load),
    .evt      (evt)
  );

endmodule
`default_nettype wire

// ----- sv/pfp_deframer.sv -----
`default_nettype none
module pfp_deframer
  import pfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] rx_byte,
  output      logic       ev_valid,
  output      evt_t       ev
);

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_SID     = 3'd1,
    PH_CID     = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  frame_header, frame_header_next;
  logic [7:0]  held_stream_id, held_stream_id_next;
  logic [31:0] held_channel_id, held_channel_id_next;
  logic [15:0] declared_length, declared_length_next;
  logic [15:0] bytes_remaining, bytes_remaining_next;
  logic [1:0]  field_byte_index, field_byte_index_next;
  logic        ack;
  logic        last;

  assign ack  = (frame_header[1:0] != 2'd0);
  assign last = (bytes_remaining <= 16'd1);

  always_comb begin
    phase_next            = phase;
    frame_header_next     = frame_header;
    held_stream_id_next   = held_stream_id;
    held_channel_id_next  = held_channel_id;
    declared_length_next  = declared_length;
    bytes_remaining_next  = bytes_remaining;
    field_byte_index_next = field_byte_index;
    ev_valid              = 1'b0;
    ev                    = '0;

    unique case (phase)
      PH_SID: begin
        held_stream_id_next = rx_byte;
        if (frame_header[7:4] == CMD_PUBACK) begin
          phase_next    = PH_HEADER;
          ev_valid      = 1'b1;
          ev.event_kind = KIND_PUBACK;
          ev.stream_id  = rx_byte;
        end else begin
          phase_next            = PH_LEN;
          field_byte_index_next = 2'd0;
        end
      end
      PH_CID: begin
        held_channel_id_next = {held_channel_id[23:0], rx_byte};
        if (field_byte_index < CID_LAST_INDEX) begin
          field_byte_index_next = field_byte_index + 2'd1;
        end else begin
          field_byte_index_next = 2'd0;
          phase_next            = PH_HEADER;
          ev_valid              = 1'b1;
          ev.event_kind         = KIND_SUBACK;
          ev.sub_channel        = {held_channel_id[23:0], rx_byte};
        end
      end
      PH_LEN: begin
        declared_length_next = {declared_length[7:0], rx_byte};
        if (field_byte_index == 2'd0) begin
          field_byte_index_next = 2'd1;
        end else begin
          field_byte_index_next = 2'd0;
          if ({declared_length[7:0], rx_byte} == 16'd0) begin
            phase_next    = PH_HEADER;
            ev_valid      = 1'b1;
            ev.event_kind = KIND_PUB_EMPTY;
            ev.stream_id  = held_stream_id;
            ev.ack_needed = ack;
          end else begin
            bytes_remaining_next = {declared_length[7:0], rx_byte};
            phase_next           = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        if (last) begin
          bytes_remaining_next = 16'd0;
          phase_next           = PH_HEADER;
        end else begin
          bytes_remaining_next = bytes_remaining - 16'd1;
        end
        ev_valid           = 1'b1;
        ev.event_kind      = KIND_PUB_BYTE;
        ev.payload_byte    = rx_byte;
        ev.last_of_message = last;
        ev.stream_id       = held_stream_id;
        ev.message_length  = declared_length;
        ev.ack_needed      = last & ack;
      end
      default: begin
        // header byte, also any unused phase code
        frame_header_next     = rx_byte;
        held_stream_id_next   = 8'd0;
        held_channel_id_next  = 32'd0;
        declared_length_next  = 16'd0;
        bytes_remaining_next  = 16'd0;
        field_byte_index_next = 2'd0;
        phase_next            = PH_HEADER;
        unique case (rx_byte[7:4])
          CMD_CONNACK: begin
            ev_valid      = 1'b1;
            ev.event_kind = KIND_CONNACK;
          end
          CMD_PINGACK: begin
            ev_valid      = 1'b1;
            ev.event_kind = KIND_PINGACK;
          end
          CMD_PUB: begin
            phase_next = (rx_byte[1:0] == 2'd0) ? PH_LEN : PH_SID;
          end
          CMD_PUBACK: begin
            phase_next = PH_SID;
          end
          CMD_SUBACK: begin
            phase_next = PH_CID;
          end
          default: begin
            ev_valid      = 1'b1;
            ev.event_kind = KIND_FRAME_ERR;
          end
        endcase
      end
    endcase

    ev.qos_level    = frame_header_next[1:0];
    ev.header_flags = frame_header_next[3:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      frame_header     <= 8'd0;
      held_stream_id   <= 8'd0;
      held_channel_id  <= 32'd0;
      declared_length  <= 16'd0;
      bytes_remaining  <= 16'd0;
      field_byte_index <= 2'd0;
    end else if (step) begin
      phase            <= phase_next;
      frame_header     <= frame_header_next;
      held_stream_id   <= held_stream_id_next;
      held_channel_id  <= held_channel_id_next;
      declared_length  <= declared_length_next;
      bytes_remaining  <= bytes_remaining_next;
      field_byte_index <= field_byte_index_next;
    end
  end

endmodule
`default_nettype wire

// ----- sv/pfp_result_reg.sv -----
`default_nettype none
module pfp_result_reg
  import pfp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic load,
  input  wire evt_t ev,
  output      logic can_load,
  pfp_evt_if.source evt
);

  logic valid;
  evt_t held;

  assign can_load = !valid || evt.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (evt.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= ev;
    end
  end

  assign evt.valid           = valid;
  assign evt.event_kind      = held.event_kind;
  assign evt.payload_byte    = held.payload_byte;
  assign evt.last_of_message = held.last_of_message;
  assign evt.stream_id       = held.stream_id;
  assign evt.sub_channel     = held.sub_channel;
  assign evt.qos_level       = held.qos_level;
  assign evt.header_flags    = held.header_flags;
  assign evt.message_length  = held.message_length;
  assign evt.ack_needed      = held.ack_needed;

endmodule
`default_nettype wire
